/* rtl/zst_pkg.sv */
// ---------------------------------------------------------------------------
// Zone state tracker package
// Shared constants, codes and types of the zone state tracker.
// ---------------------------------------------------------------------------
package zst_pkg;

   // Geometry
   localparam int ZONES           = 64;
   localparam int BLOCKS_PER_ZONE = 4096;
   localparam int ZONE_W          = $clog2(ZONES);
   localparam int OFS_W           = $clog2(BLOCKS_PER_ZONE);

   // Field widths
   localparam int CMD_W        = 3;
   localparam int ZONE_FIELD_W = 6;
   localparam int ADDR_W       = 18;
   localparam int STATUS_W     = 3;
   localparam int PTR_W        = 13;
   localparam int CNT_W        = 7;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 13;

   // Register reset values
   localparam logic [CNT_W-1:0] MAX_OPEN_RESET   = CNT_W'(8);
   localparam logic [CNT_W-1:0] MAX_ACTIVE_RESET = CNT_W'(16);
   localparam logic [PTR_W-1:0] ZONE_CAP_RESET   = PTR_W'(4096);

   typedef enum logic [CMD_W-1:0] {
      CMD_OPEN       = 3'd0,
      CMD_CLOSE      = 3'd1,
      CMD_FINISH     = 3'd2,
      CMD_RESET      = 3'd3,
      CMD_WRITTEN    = 3'd4,
      CMD_INVALIDATE = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_MAX_OPEN   = 3'd1,
      ST_MAX_ACTIVE = 3'd2,
      ST_COND       = 3'd3,
      ST_DEV_ERR    = 3'd4,
      ST_UNKNOWN    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      COND_EMPTY  = 2'd0,
      COND_OPEN   = 2'd1,
      COND_CLOSED = 2'd2,
      COND_FULL   = 2'd3
   } cond_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_OPEN   = 2'd0,
      CSR_MAX_ACTIVE = 2'd1,
      CSR_ZONE_CAP   = 2'd2
   } csr_index_type;

   typedef struct packed {
      cond_type           cond;
      logic [PTR_W-1:0]   wp;
      logic [PTR_W-1:0]   vc;
      logic               in_open;
      logic               in_active;
   } zone_entry_type;

   localparam zone_entry_type ENTRY_RESET = '{
      cond: COND_EMPTY, wp: '0, vc: '0, in_open: 1'b0, in_active: 1'b0
   };

   typedef struct packed {
      logic [CNT_W-1:0] max_open;
      logic [CNT_W-1:0] max_active;
      logic [PTR_W-1:0] zone_cap;
   } cfg_type;

   // Decoded command held in the input register
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ZONE_W-1:0] zone;
      logic              in_range;
      logic [OFS_W-1:0]  offset;
      logic              device_ok;
   } item_type;

   typedef struct packed {
      status_type       status;
      logic             have_zone;
      zone_entry_type   entry;
      logic [CNT_W-1:0] open_total;
      logic [CNT_W-1:0] active_total;
   } eval_res_type;

endpackage

/* rtl/zst_req_if.sv */
// ---------------------------------------------------------------------------
// Zone state tracker command channel
// Valid/ready channel carrying one zone command per transaction.
// ---------------------------------------------------------------------------
interface zst_req_if
   import zst_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [ZONE_FIELD_W-1:0] zone;
   logic [ADDR_W-1:0]       block_address;
   logic                    device_ok;

   modport source (output valid, command, zone, block_address, device_ok, input ready);
   modport sink   (input valid, command, zone, block_address, device_ok, output ready);
endinterface

/* rtl/zst_rsp_if.sv */
// ---------------------------------------------------------------------------
// Zone state tracker result channel
// Valid/ready channel carrying one command result per transaction.
// ---------------------------------------------------------------------------
interface zst_rsp_if
   import zst_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [1:0]          zone_condition;
   logic [PTR_W-1:0]    write_pointer;
   logic [PTR_W-1:0]    valid_count;
   logic [CNT_W-1:0]    open_count;
   logic [CNT_W-1:0]    active_count;

   modport source (output valid, status, zone_condition, write_pointer, valid_count,
                   open_count, active_count, input ready);
   modport sink   (input valid, status, zone_condition, write_pointer, valid_count,
                   open_count, active_count, output ready);
endinterface

/* rtl/zst_cmd_eval.sv */
// ---------------------------------------------------------------------------
// Zone command evaluator
// Checks one command against the zone entry and set limits, and forms the
// updated entry, set totals and status.
// ---------------------------------------------------------------------------
module zst_cmd_eval
   import zst_pkg::*;
(
   input  item_type         item,
   input  zone_entry_type   cur,
   input  logic [CNT_W-1:0] open_total,
   input  logic [CNT_W-1:0] active_total,
   input  cfg_type          cfg,
   output eval_res_type     res
);

   function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
      return (&v) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] v);
      return (v == '0) ? v : v - CNT_W'(1);
   endfunction

   logic [PTR_W-1:0] cap_in_use;
   logic [PTR_W-1:0] next_wp;

   assign cap_in_use = (cfg.zone_cap < PTR_W'(BLOCKS_PER_ZONE)) ?
                       cfg.zone_cap : PTR_W'(BLOCKS_PER_ZONE);
   assign next_wp    = PTR_W'(item.offset) + PTR_W'(1);

   always_comb begin
      zone_entry_type   nxt;
      logic [CNT_W-1:0] ot;
      logic [CNT_W-1:0] at;
      status_type       st;
      logic             have;
      nxt  = cur;
      ot   = open_total;
      at   = active_total;
      st   = ST_OK;
      have = 1'b1;

      unique case (cmd_type'(item.cmd))
         CMD_OPEN, CMD_CLOSE, CMD_FINISH, CMD_RESET, CMD_WRITTEN, CMD_INVALIDATE: begin
            if (!item.in_range) begin
               st   = ST_COND;
               have = 1'b0;
            end
         end
         default: begin
            st   = ST_UNKNOWN;
            have = 1'b0;
         end
      endcase

      if (have) begin
         unique case (cmd_type'(item.cmd))
            CMD_OPEN: begin
               priority if (cur.cond == COND_OPEN) begin
                  st = ST_OK;
               end else if (cur.cond == COND_FULL) begin
                  st = ST_COND;
               end else if (ot >= cfg.max_open) begin
                  st = ST_MAX_OPEN;
               end else if (!cur.in_active && at >= cfg.max_active) begin
                  st = ST_MAX_ACTIVE;
               end else if (!item.device_ok) begin
                  st = ST_DEV_ERR;
               end else begin
                  if (!nxt.in_open) begin
                     nxt.in_open = 1'b1;
                     ot          = cnt_inc(ot);
                  end
                  if (!nxt.in_active) begin
                     nxt.in_active = 1'b1;
                     at            = cnt_inc(at);
                  end
                  nxt.cond = COND_OPEN;
               end
            end
            CMD_CLOSE: begin
               priority if (cur.cond != COND_OPEN) begin
                  st = ST_COND;
               end else if (!item.device_ok) begin
                  st = ST_DEV_ERR;
               end else begin
                  if (nxt.in_open) begin
                     nxt.in_open = 1'b0;
                     ot          = cnt_dec(ot);
                  end
                  nxt.cond = COND_CLOSED;
               end
            end
            CMD_FINISH, CMD_RESET: begin
               priority if (cmd_type'(item.cmd) == CMD_FINISH && cur.cond == COND_EMPTY) begin
                  st = ST_COND;
               end else if (!item.device_ok) begin
                  st = ST_DEV_ERR;
               end else begin
                  if (nxt.in_open) begin
                     nxt.in_open = 1'b0;
                     ot          = cnt_dec(ot);
                  end
                  if (nxt.in_active) begin
                     nxt.in_active = 1'b0;
                     at            = cnt_dec(at);
                  end
                  if (cmd_type'(item.cmd) == CMD_FINISH) begin
                     nxt.cond = COND_FULL;
                     nxt.wp   = cap_in_use;
                  end else begin
                     nxt.cond = COND_EMPTY;
                     nxt.wp   = '0;
                     nxt.vc   = '0;
                  end
               end
            end
            CMD_WRITTEN: begin
               if (cur.vc < PTR_W'(BLOCKS_PER_ZONE)) begin
                  nxt.vc = cur.vc + PTR_W'(1);
               end
               if (next_wp > cur.wp) begin
                  nxt.wp = next_wp;
               end
               if (nxt.wp >= cap_in_use) begin
                  nxt.cond = COND_FULL;
                  if (nxt.in_active) begin
                     nxt.in_active = 1'b0;
                     at            = cnt_dec(at);
                  end
                  if (nxt.in_open) begin
                     nxt.in_open = 1'b0;
                     ot          = cnt_dec(ot);
                  end
               end
            end
            default: begin
               // block invalidated
               if (cur.vc != '0) begin
                  nxt.vc = cur.vc - PTR_W'(1);
               end
            end
         endcase
      end

      res.status       = st;
      res.have_zone    = have;
      res.entry        = nxt;
      res.open_total   = ot;
      res.active_total = at;
   end

endmodule

/* rtl/zoned_storage_zone_state_tracker_core.sv */
// ---------------------------------------------------------------------------
// Zone state tracker core
// Tracks condition, write pointer, valid blocks and open/active set
// membership for every zone, and answers each zone command with one result.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one command per transaction (open, close, finish, reset,
//   block written, block invalidated). rsp_chan returns exactly one result per
//   command, in order. csr_we/csr_index/csr_wdata write max_open (0),
//   max_active (1) and zone_capacity_blocks (2); write only while idle.
// Pipeline and throughput:
//   a command sits in the input register, whose zone entry is read from the zone
//   memory at the accepting edge, and is evaluated into the result register once
//   that register is empty or being emptied; the result is taken from there
//   while rsp_chan is ready. One command is accepted every cycle while rsp_chan
//   is ready; one read and one write of the zone memory per cycle, plus a bypass
//   of the last written entry, set that rate.
// Reset:
//   synchronous; clears the per-zone valid bits so every zone reads as empty
//   with zero pointer and count, clears both set totals and loads the register
//   defaults. No clearing pass over the memory is needed.
// Stall:
//   while rsp_chan is held off the result register holds, the input register
//   holds and req_chan.ready drops once both are full.
// ---------------------------------------------------------------------------
module zoned_storage_zone_state_tracker_core
   import zst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   zst_req_if.sink               req_chan,
   zst_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Configuration registers
   cfg_type cfg_ff;

   // Zone memory and per-entry valid bits
   zone_entry_type    zone_mem [ZONES];
   logic [ZONES-1:0]  entry_valid_ff;

   // Input register stage
   logic              s1_valid_ff;
   item_type          s1_item_ff;
   item_type          s1_item_in;
   zone_entry_type    rd_data_ff;
   logic              rd_valid_ff;

   // Last write bypass
   logic              lw_valid_ff;
   logic [ZONE_W-1:0] lw_zone_ff;
   zone_entry_type    lw_data_ff;

   // Set totals
   logic [CNT_W-1:0]  open_total_ff;
   logic [CNT_W-1:0]  active_total_ff;

   // Result register
   logic              rsp_valid_ff;
   eval_res_type      rsp_res_ff;

   logic              req_fire;
   logic              s1_fire;
   logic [ADDR_W-1:0] zone_num;
   zone_entry_type    cur_entry;
   eval_res_type      eval_res;

   // ---------------------------------------------------------------------
   // Handshake: advance the input register whenever the result register is
   // empty or is being emptied
   // ---------------------------------------------------------------------
   assign s1_fire        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // ---------------------------------------------------------------------
   // Decode the target zone: block commands address it through the global
   // block number, the others name it directly
   // ---------------------------------------------------------------------
   always_comb begin
      if (req_chan.command == CMD_WRITTEN || req_chan.command == CMD_INVALIDATE) begin
         zone_num = ADDR_W'(req_chan.block_address >> OFS_W);
      end else begin
         zone_num = ADDR_W'(req_chan.zone);
      end
      s1_item_in.cmd       = req_chan.command;
      s1_item_in.zone      = zone_num[ZONE_W-1:0];
      s1_item_in.in_range  = zone_num < ADDR_W'(ZONES);
      s1_item_in.offset    = req_chan.block_address[OFS_W-1:0];
      s1_item_in.device_ok = req_chan.device_ok;
   end

   // Hold the command; read its zone entry at the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff  <= s1_item_in;
         rd_data_ff  <= zone_mem[s1_item_in.zone];
         rd_valid_ff <= entry_valid_ff[s1_item_in.zone];
      end
   end

   // ---------------------------------------------------------------------
   // Current entry: the last write wins when it hit the same zone (covers a
   // read that raced the write); a never-written entry reads as reset
   // ---------------------------------------------------------------------
   always_comb begin
      priority if (lw_valid_ff && lw_zone_ff == s1_item_ff.zone) begin
         cur_entry = lw_data_ff;
      end else if (rd_valid_ff) begin
         cur_entry = rd_data_ff;
      end else begin
         cur_entry = ENTRY_RESET;
      end
   end

   zst_cmd_eval u_eval (
      .item         (s1_item_ff),
      .cur          (cur_entry),
      .open_total   (open_total_ff),
      .active_total (active_total_ff),
      .cfg          (cfg_ff),
      .res          (eval_res)
   );

   // Write back the entry of every known, in-range command
   always_ff @(posedge clock) begin
      if (s1_fire && eval_res.have_zone) begin
         zone_mem[s1_item_ff.zone] <= eval_res.entry;
         lw_zone_ff                <= s1_item_ff.zone;
         lw_data_ff                <= eval_res.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff  <= '0;
         lw_valid_ff     <= 1'b0;
         open_total_ff   <= '0;
         active_total_ff <= '0;
      end else if (s1_fire) begin
         open_total_ff   <= eval_res.open_total;
         active_total_ff <= eval_res.active_total;
         if (eval_res.have_zone) begin
            entry_valid_ff[s1_item_ff.zone] <= 1'b1;
            lw_valid_ff                     <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register: load on advance, drop once taken
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_res_ff <= eval_res;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_res_ff.status;
   assign rsp_chan.zone_condition = rsp_res_ff.have_zone ? rsp_res_ff.entry.cond : COND_EMPTY;
   assign rsp_chan.write_pointer  = rsp_res_ff.have_zone ? rsp_res_ff.entry.wp : '0;
   assign rsp_chan.valid_count    = rsp_res_ff.have_zone ? rsp_res_ff.entry.vc : '0;
   assign rsp_chan.open_count     = rsp_res_ff.open_total;
   assign rsp_chan.active_count   = rsp_res_ff.active_total;

   // ---------------------------------------------------------------------
   // Configuration writes; an index beyond the register list is ignored
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_open   <= MAX_OPEN_RESET;
         cfg_ff.max_active <= MAX_ACTIVE_RESET;
         cfg_ff.zone_cap   <= ZONE_CAP_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_OPEN:   cfg_ff.max_open   <= csr_wdata[CNT_W-1:0];
            CSR_MAX_ACTIVE: cfg_ff.max_active <= csr_wdata[CNT_W-1:0];
            CSR_ZONE_CAP:   cfg_ff.zone_cap   <= csr_wdata[PTR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Every open zone is also active, so the open total never passes the
   // active total
   a_open_within_active: assert property (@(posedge clock) disable iff (reset)
      open_total_ff <= active_total_ff)
      else $error("open total exceeds active total");

   // Set totals are bounded by the number of zones
   a_totals_bounded: assert property (@(posedge clock) disable iff (reset)
      open_total_ff <= CNT_W'(ZONES) && active_total_ff <= CNT_W'(ZONES))
      else $error("set total exceeds zone count");

   // A result of an unknown command carries zeroed pointer and count fields
   a_no_zone_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_res_ff.status == ST_UNKNOWN)) |->
      (rsp_chan.write_pointer == '0 && rsp_chan.valid_count == '0))
      else $error("unknown command result carries zone data");

   // An advancing command always leaves a result waiting in the next cycle
   a_advance_loads_result: assert property (@(posedge clock) disable iff (reset)
      s1_fire |=> rsp_valid_ff)
      else $error("advanced command produced no result");

endmodule

/* tb/zst_command_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Zone state tracker result checker
// Watches the command, result and register ports of the zone state tracker.
// Keeps its own copy of every zone entry, the set totals and the register
// values, predicts one result per accepted command and compares each
// accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module zst_command_checker
   import zst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   zst_req_if                    req_chan,
   zst_rsp_if                    rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           failures,
   output int unsigned           outstanding,
   output int unsigned           checked
);

   typedef struct {
      status_type       status;
      cond_type         cond;
      logic [PTR_W-1:0] wp;
      logic [PTR_W-1:0] vc;
      logic [CNT_W-1:0] open_n;
      logic [CNT_W-1:0] active_n;
   } zone_result_type;

   // Shadow copy of the zone table and registers
   cond_type         zone_cond [ZONES];
   logic [PTR_W-1:0] zone_wp [ZONES];
   logic [PTR_W-1:0] zone_vc [ZONES];
   bit               open_mark [ZONES];
   bit               active_mark [ZONES];
   logic [CNT_W-1:0] open_total;
   logic [CNT_W-1:0] active_total;
   logic [CNT_W-1:0] max_open;
   logic [CNT_W-1:0] max_active;
   logic [PTR_W-1:0] zone_cap;

   zone_result_type  pending_results [$];

   function automatic void clear_zone_table();
      for (int i = 0; i < ZONES; i++) begin
         zone_cond[i]   = COND_EMPTY;
         zone_wp[i]     = '0;
         zone_vc[i]     = '0;
         open_mark[i]   = 1'b0;
         active_mark[i] = 1'b0;
      end
      open_total   = '0;
      active_total = '0;
      max_open     = MAX_OPEN_RESET;
      max_active   = MAX_ACTIVE_RESET;
      zone_cap     = ZONE_CAP_RESET;
   endfunction

   function automatic void leave_open(input int z);
      if (open_mark[z]) begin
         open_mark[z] = 1'b0;
         if (open_total != '0) open_total = open_total - 1'b1;
      end
   endfunction

   function automatic void leave_active(input int z);
      if (active_mark[z]) begin
         active_mark[z] = 1'b0;
         if (active_total != '0) active_total = active_total - 1'b1;
      end
   endfunction

   // Apply one command to the shadow table and return the result it gives
   function automatic zone_result_type apply_command(input logic [CMD_W-1:0]        cmd,
                                                     input logic [ZONE_FIELD_W-1:0] zone_field,
                                                     input logic [ADDR_W-1:0]       addr,
                                                     input logic                    ok);
      zone_result_type  res;
      int               z;
      int               offset;
      bit               known;
      logic [PTR_W-1:0] cap;
      logic [PTR_W-1:0] next_ptr;
      res.status = ST_OK;
      known      = 1'b1;
      cap        = (zone_cap < PTR_W'(BLOCKS_PER_ZONE)) ? zone_cap : PTR_W'(BLOCKS_PER_ZONE);
      offset     = int'(addr) % BLOCKS_PER_ZONE;
      if (cmd == CMD_WRITTEN || cmd == CMD_INVALIDATE) z = int'(addr) / BLOCKS_PER_ZONE;
      else z = int'(zone_field);

      if (cmd > CMD_INVALIDATE) begin
         res.status = ST_UNKNOWN;
         known      = 1'b0;
      end else if (z >= ZONES) begin
         res.status = ST_COND;
         known      = 1'b0;
      end else begin
         case (cmd)
            CMD_OPEN: begin
               if (zone_cond[z] == COND_OPEN) res.status = ST_OK;
               else if (zone_cond[z] == COND_FULL) res.status = ST_COND;
               else if (open_total >= max_open) res.status = ST_MAX_OPEN;
               else if (!active_mark[z] && active_total >= max_active)
                  res.status = ST_MAX_ACTIVE;
               else if (!ok) res.status = ST_DEV_ERR;
               else begin
                  if (!open_mark[z]) begin
                     open_mark[z] = 1'b1;
                     if (open_total != '1) open_total = open_total + 1'b1;
                  end
                  if (!active_mark[z]) begin
                     active_mark[z] = 1'b1;
                     if (active_total != '1) active_total = active_total + 1'b1;
                  end
                  zone_cond[z] = COND_OPEN;
               end
            end
            CMD_CLOSE: begin
               if (zone_cond[z] != COND_OPEN) res.status = ST_COND;
               else if (!ok) res.status = ST_DEV_ERR;
               else begin
                  leave_open(z);
                  zone_cond[z] = COND_CLOSED;
               end
            end
            CMD_FINISH: begin
               if (zone_cond[z] == COND_EMPTY) res.status = ST_COND;
               else if (!ok) res.status = ST_DEV_ERR;
               else begin
                  leave_open(z);
                  leave_active(z);
                  zone_cond[z] = COND_FULL;
                  zone_wp[z]   = cap;
               end
            end
            CMD_RESET: begin
               // Allowed in any condition; only the device can refuse it
               if (!ok) res.status = ST_DEV_ERR;
               else begin
                  leave_open(z);
                  leave_active(z);
                  zone_cond[z] = COND_EMPTY;
                  zone_wp[z]   = '0;
                  zone_vc[z]   = '0;
               end
            end
            CMD_WRITTEN: begin
               // No condition check: the pointer only moves forward
               next_ptr = PTR_W'(offset + 1);
               if (zone_vc[z] < PTR_W'(BLOCKS_PER_ZONE)) zone_vc[z] = zone_vc[z] + 1'b1;
               if (next_ptr > zone_wp[z]) zone_wp[z] = next_ptr;
               if (zone_wp[z] >= cap) begin
                  zone_cond[z] = COND_FULL;
                  leave_active(z);
                  leave_open(z);
               end
            end
            default: begin
               if (zone_vc[z] != '0) zone_vc[z] = zone_vc[z] - 1'b1;
            end
         endcase
      end

      if (known) begin
         res.cond = zone_cond[z];
         res.wp   = zone_wp[z];
         res.vc   = zone_vc[z];
      end else begin
         res.cond = COND_EMPTY;
         res.wp   = '0;
         res.vc   = '0;
      end
      res.open_n   = open_total;
      res.active_n = active_total;
      return res;
   endfunction

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      zone_result_type want;
      if (reset) begin
         clear_zone_table();
         pending_results.delete();
         failures    = 0;
         outstanding = 0;
         checked     = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_OPEN:   max_open   = csr_wdata[CNT_W-1:0];
               CSR_MAX_ACTIVE: max_active = csr_wdata[CNT_W-1:0];
               CSR_ZONE_CAP:   zone_cap   = csr_wdata[PTR_W-1:0];
               default: ;
            endcase
         end
         // Retire the result first: a command never answers in its own cycle
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $error("result transaction with no command outstanding");
               failures++;
            end else begin
               want = pending_results.pop_front();
               check_field("status", want.status, rsp_chan.status);
               check_field("zone_condition", want.cond, rsp_chan.zone_condition);
               check_field("write_pointer", want.wp, rsp_chan.write_pointer);
               check_field("valid_count", want.vc, rsp_chan.valid_count);
               check_field("open_count", want.open_n, rsp_chan.open_count);
               check_field("active_count", want.active_n, rsp_chan.active_count);
               checked++;
            end
         end
         if (req_chan.valid && req_chan.ready)
            pending_results.push_back(apply_command(req_chan.command, req_chan.zone,
                                                    req_chan.block_address,
                                                    req_chan.device_ok));
         outstanding = pending_results.size();
      end
   end

endmodule

/* tb/zoned_storage_zone_state_tracker_core_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Zone state tracker regression
// Drives zone commands into the tracker under several register settings:
// a directed pass over every command, the condition rules and the open and
// active limits, then weighted random traffic on a few busy zones. Both
// channels idle at random. A separate checker predicts and compares every
// result; this module only makes stimulus and gives the verdict.
// ---------------------------------------------------------------------------
module zoned_storage_zone_state_tracker_core_test;
   import zst_pkg::*;

   // Command codes the block does not know
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned failures;
   int unsigned outstanding;
   int unsigned checked;
   int unsigned sent_count;
   int unsigned settings_count;
   int unsigned cap_live;
   bit          steady;

   zst_req_if req_chan ();
   zst_rsp_if rsp_chan ();

   zoned_storage_zone_state_tracker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   zst_command_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop, well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Mostly no pause, sometimes a short one, rarely a long one; none at all
   // while a steady stretch is running.
   function automatic int unsigned pause_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side: hold ready high for a burst, then drop it for a pause
   initial begin
      int unsigned stall;
      rsp_chan.ready = 1'b1;
      forever begin
         rsp_chan.ready = 1'b1;
         repeat ($urandom_range(1, 50)) @(negedge clock);
         stall = pause_length();
         if (stall != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   function automatic logic [ADDR_W-1:0] block_at(input int unsigned zone,
                                                  input int unsigned offset);
      return {ZONE_W'(zone), OFS_W'(offset)};
   endfunction

   // Offer one command transaction; hold it until the block takes it
   task automatic send_command(input logic [CMD_W-1:0]        cmd,
                               input logic [ZONE_FIELD_W-1:0] zone,
                               input logic [ADDR_W-1:0]       addr,
                               input logic                    ok);
      int unsigned gap;
      gap = pause_length();
      if (gap != 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid         = 1'b1;
      req_chan.command       = cmd;
      req_chan.zone          = zone;
      req_chan.block_address = addr;
      req_chan.device_ok     = ok;
      do @(posedge clock); while (!req_chan.ready);
      sent_count++;
   endtask

   task automatic release_channel();
      @(negedge clock);
      req_chan.valid = 1'b0;
   endtask

   task automatic write_register(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   // Drain every outstanding result, then load a new register set
   task automatic apply_settings(input int unsigned open_limit, input int unsigned active_limit,
                                 input int unsigned capacity);
      release_channel();
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(negedge clock);
      write_register(CSR_MAX_OPEN, open_limit);
      write_register(CSR_MAX_ACTIVE, active_limit);
      write_register(CSR_ZONE_CAP, capacity);
      cap_live = (capacity < BLOCKS_PER_ZONE) ? capacity : BLOCKS_PER_ZONE;
      settings_count++;
   endtask

   // One weighted random command aimed at a small set of busy zones
   task automatic random_command(input int unsigned hot_span);
      int unsigned        pick;
      int unsigned        back;
      logic [CMD_W-1:0]   cmd;
      logic [ZONE_W-1:0]  zone_sel;
      logic [OFS_W-1:0]   offset;
      logic [ADDR_W-1:0]  addr;
      pick = $urandom_range(0, 99);
      if (pick < 20) cmd = CMD_OPEN;
      else if (pick < 32) cmd = CMD_CLOSE;
      else if (pick < 40) cmd = CMD_FINISH;
      else if (pick < 48) cmd = CMD_RESET;
      else if (pick < 78) cmd = CMD_WRITTEN;
      else if (pick < 94) cmd = CMD_INVALIDATE;
      else cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;

      if ($urandom_range(0, 9) < 8) zone_sel = ZONE_W'($urandom_range(0, hot_span));
      else zone_sel = ZONE_W'($urandom_range(0, ZONES - 1));

      // Offsets: low in the zone, just short of capacity, or anywhere
      pick = $urandom_range(0, 9);
      back = $urandom_range(0, 3);
      if (pick < 4) offset = OFS_W'($urandom_range(0, 15));
      else if (pick < 7) offset = OFS_W'((cap_live > back) ? cap_live - 1 - back : 0);
      else offset = OFS_W'($urandom_range(0, BLOCKS_PER_ZONE - 1));

      // Zone commands carry a random, ignored address
      if (cmd == CMD_WRITTEN || cmd == CMD_INVALIDATE) addr = {zone_sel, offset};
      else addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));

      send_command(cmd, ZONE_FIELD_W'(zone_sel), addr, $urandom_range(0, 99) < 88);
   endtask

   task automatic random_phase(input int unsigned count, input int unsigned hot_span);
      repeat (count) random_command(hot_span);
   endtask

   initial begin
      int unsigned waited;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = CSR_MAX_OPEN;
      csr_wdata              = '0;
      req_chan.valid         = 1'b0;
      req_chan.command       = CMD_OPEN;
      req_chan.zone          = '0;
      req_chan.block_address = '0;
      req_chan.device_ok     = 1'b0;
      sent_count             = 0;
      settings_count         = 0;
      steady                 = 1'b0;
      cap_live               = BLOCKS_PER_ZONE;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Register defaults: walk the condition rules on a few zones
      send_command(CMD_OPEN, 0, '0, 1'b1);
      send_command(CMD_OPEN, 0, '0, 1'b0);           // already open: no change
      send_command(CMD_CLOSE, 0, '0, 1'b0);          // device refuses
      send_command(CMD_CLOSE, 0, '1, 1'b1);
      send_command(CMD_CLOSE, 0, '0, 1'b1);          // not open
      send_command(CMD_FINISH, 1, '0, 1'b1);         // finish of an empty zone
      send_command(CMD_OPEN, 1, '0, 1'b0);           // device refuses
      send_command(CMD_WRITTEN, 0, block_at(0, 0), 1'b0);
      send_command(CMD_WRITTEN, 0, block_at(0, BLOCKS_PER_ZONE - 1), 1'b1); // fills it
      send_command(CMD_OPEN, 0, '0, 1'b1);           // full zone
      send_command(CMD_INVALIDATE, 0, block_at(0, 7), 1'b1);
      send_command(CMD_INVALIDATE, 0, block_at(0, 7), 1'b1);
      send_command(CMD_INVALIDATE, 0, block_at(0, 7), 1'b1); // count floors at zero
      send_command(CMD_RESET, 0, '0, 1'b0);
      send_command(CMD_RESET, 0, '0, 1'b1);
      send_command(CMD_OPEN, ZONES - 1, '0, 1'b1);
      send_command(CMD_FINISH, ZONES - 1, '0, 1'b0);
      send_command(CMD_FINISH, ZONES - 1, '0, 1'b1);
      send_command(CMD_WRITTEN, 0, '1, 1'b1);        // last block of the last zone
      send_command(CMD_SPARE_LO, '1, '1, 1'b1);
      send_command(CMD_SPARE_HI, '0, '0, 1'b0);

      // Tightest limits and a one-block zone
      apply_settings(1, 2, 1);
      send_command(CMD_OPEN, 10, '0, 1'b1);
      send_command(CMD_OPEN, 11, '0, 1'b1);          // open limit reached
      send_command(CMD_CLOSE, 10, '0, 1'b1);
      send_command(CMD_OPEN, 11, '0, 1'b1);
      send_command(CMD_CLOSE, 11, '0, 1'b1);
      send_command(CMD_OPEN, 12, '0, 1'b1);          // active limit reached
      send_command(CMD_OPEN, 10, '0, 1'b1);          // closed zone needs no new slot
      send_command(CMD_WRITTEN, 0, block_at(12, 0), 1'b1);
      send_command(CMD_FINISH, 10, '0, 1'b1);
      random_phase(150, 5);

      apply_settings(MAX_OPEN_RESET, MAX_ACTIVE_RESET, BLOCKS_PER_ZONE);
      random_phase(200, 11);

      // Widest limits over the whole zone range, both sides flat out
      apply_settings(ZONES, ZONES, BLOCKS_PER_ZONE);
      steady = 1'b1;
      random_phase(250, ZONES - 1);
      steady = 1'b0;

      apply_settings(3, 5, 16);
      random_phase(250, 9);

      apply_settings($urandom_range(1, ZONES), $urandom_range(1, ZONES),
                     $urandom_range(1, BLOCKS_PER_ZONE));
      random_phase(250, 15);

      // Drain the last results, bounded, then allow for the pipeline
      release_channel();
      waited = 0;
      while (outstanding != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (outstanding != 0) $error("%0d results never arrived", outstanding);

      $display("%0d commands over %0d register settings, %0d results checked",
               sent_count, settings_count + 1, checked);
      if (failures == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/zst_pkg.sv
rtl/zst_req_if.sv
rtl/zst_rsp_if.sv
rtl/zst_cmd_eval.sv
rtl/zoned_storage_zone_state_tracker_core.sv
tb/zst_command_checker.sv
tb/zoned_storage_zone_state_tracker_core_test.sv
